// ===== rtl/lcr_pkg.sv =====
package lcr_pkg;

  localparam int VALUE_BITS  = 12;
  localparam int LEN_BITS    = VALUE_BITS + 1;
  localparam int IN_VALUE_W  = 12;
  localparam int OUT_LEN_W   = 13;
  localparam int TABLE_DEPTH = 1 << VALUE_BITS;

  typedef logic [VALUE_BITS-1:0] addr_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [OUT_LEN_W-1:0]  olen_t;

  localparam addr_t ADDR_MAX   = {VALUE_BITS{1'b1}};
  localparam logic  ACT_INSERT = 1'b0;
  localparam logic  ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [IN_VALUE_W-1:0] value;
  } lcr_in_t;

  typedef struct packed {
    olen_t best_length;
    olen_t run_length;
    logic  repeated;
  } lcr_out_t;

  // One table entry: presence bit and, at run ends, the run length
  typedef struct packed {
    logic present;
    len_t len;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } mem_req_t;

endpackage

// ===== rtl/lcr_table.sv =====
module lcr_table (
  input  logic              clk,
  input  lcr_pkg::mem_req_t req,
  output lcr_pkg::entry_t   rd_a_r,
  output lcr_pkg::entry_t   rd_b_r
);

  lcr_pkg::entry_t mem [lcr_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

endmodule

// ===== rtl/longest_consecutive_run_tracker.sv =====
// Longest run of consecutive values. Each transaction either inserts a value
// or clears the set, and gives exactly one result, shown for one cycle while
// out_valid is high; the receiver cannot stall, so it must take every result.
// Presence bits and run-end lengths live in one table of 2^VALUE_BITS entries
// with two read ports and one write port. An insert keeps busy high while
// neighbors are read, then the value's own entry, then the run ends (and, when
// the value joins two runs, the value's own entry) are written one per cycle
// through the single write port. A repeated value keeps busy high while the
// neighbors and its own entry are read. A clear gives its result in the cycle
// after it is taken and then sweeps the table, one entry per cycle, with busy
// high until the sweep ends. After reset the same sweep runs before the first
// transaction is taken.
module longest_consecutive_run_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lcr_pkg::lcr_in_t  in_data,
  output logic              out_valid,
  output lcr_pkg::lcr_out_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_NBR  = 7'b0000010,
    S_SELF = 7'b0000100,
    S_WLO  = 7'b0001000,
    S_WHI  = 7'b0010000,
    S_WMID = 7'b0100000,
    S_CLR  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  lcr_pkg::addr_t    v_r, v_nxt;
  lcr_pkg::addr_t    clr_cnt_r, clr_cnt_nxt;
  lcr_pkg::len_t     left_r, left_nxt;
  lcr_pkg::len_t     right_r, right_nxt;
  lcr_pkg::len_t     total_r, total_nxt;
  lcr_pkg::len_t     best_r, best_nxt;
  logic              out_valid_r, out_valid_nxt;
  lcr_pkg::lcr_out_t out_data_r, out_data_nxt;

  lcr_pkg::mem_req_t req;
  lcr_pkg::entry_t   rd_a_r, rd_b_r;
  lcr_pkg::addr_t    v_in;
  logic              accept;

  lcr_table u_table (
    .clk    (clk),
    .req    (req),
    .rd_a_r (rd_a_r),
    .rd_b_r (rd_b_r)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign v_in      = lcr_pkg::addr_t'(in_data.value);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    clr_cnt_nxt   = clr_cnt_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    total_nxt     = total_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    req.we      = 1'b0;
    req.waddr   = v_r;
    req.wdata   = '0;
    req.raddr_a = v_in - lcr_pkg::addr_t'(1);
    req.raddr_b = v_in + lcr_pkg::addr_t'(1);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          v_nxt = v_in;
          if (in_data.action == lcr_pkg::ACT_CLEAR) begin
            best_nxt                 = '0;
            clr_cnt_nxt              = '0;
            out_valid_nxt            = 1'b1;
            out_data_nxt.best_length = '0;
            out_data_nxt.run_length  = '0;
            out_data_nxt.repeated    = 1'b0;
            state_nxt                = S_CLR;
          end else begin
            state_nxt = S_NBR;
          end
        end
      end
      S_NBR: begin
        // Neighbors at the table edges do not exist: runs never wrap
        left_nxt  = (v_r != '0 && rd_a_r.present) ? rd_a_r.len : '0;
        right_nxt = (v_r != lcr_pkg::ADDR_MAX && rd_b_r.present) ? rd_b_r.len : '0;
        total_nxt = left_nxt + right_nxt + lcr_pkg::len_t'(1);
        req.raddr_a = v_r;
        state_nxt   = S_SELF;
      end
      S_SELF: begin
        out_valid_nxt = 1'b1;
        if (rd_a_r.present) begin
          out_data_nxt.best_length = lcr_pkg::olen_t'(best_r);
          out_data_nxt.run_length  = '0;
          out_data_nxt.repeated    = 1'b1;
          state_nxt                = S_IDLE;
        end else begin
          if (total_r > best_r) begin
            best_nxt = total_r;
          end
          out_data_nxt.best_length = lcr_pkg::olen_t'(best_nxt);
          out_data_nxt.run_length  = lcr_pkg::olen_t'(total_r);
          out_data_nxt.repeated    = 1'b0;
          // Left end of the merged run
          req.we          = 1'b1;
          req.waddr       = v_r - left_r[lcr_pkg::VALUE_BITS-1:0];
          req.wdata.present = 1'b1;
          req.wdata.len   = total_r;
          state_nxt       = S_WHI;
        end
      end
      S_WLO: begin
        state_nxt = S_IDLE;
      end
      S_WHI: begin
        // Right end of the merged run
        req.we            = 1'b1;
        req.waddr         = v_r + right_r[lcr_pkg::VALUE_BITS-1:0];
        req.wdata.present = 1'b1;
        req.wdata.len     = total_r;
        state_nxt = (left_r != '0 && right_r != '0) ? S_WMID : S_IDLE;
      end
      S_WMID: begin
        // Value sits inside the joined run: only its presence matters
        req.we            = 1'b1;
        req.waddr         = v_r;
        req.wdata.present = 1'b1;
        req.wdata.len     = total_r;
        state_nxt         = S_IDLE;
      end
      S_CLR: begin
        req.we      = 1'b1;
        req.waddr   = clr_cnt_r;
        req.wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + lcr_pkg::addr_t'(1);
        if (clr_cnt_r == lcr_pkg::ADDR_MAX) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  // A clear taken right after a repeated value gives the next strobe at once
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(accept && in_data.action == lcr_pkg::ACT_CLEAR) |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_SELF) ||
                  ($past(accept) && $past(in_data.action) == lcr_pkg::ACT_CLEAR))
    else $error("result strobe without a finished transaction");

  a_repeat_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.repeated |-> out_data.run_length == '0)
    else $error("repeated value reports a run length");

  a_best_covers_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.repeated |-> best_r >= lcr_pkg::len_t'(out_data.run_length))
    else $error("best length below the run just reported");

  a_busy_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) && $past(in_data.action) == lcr_pkg::ACT_CLEAR |-> busy)
    else $error("clear taken without a table sweep");

endmodule
